FILE: hw/rtl/h2r_pkg.sv
// Shared constants and types for the HSV to RGB converter.
`timescale 1ns / 1ps
`default_nettype none

package h2r_pkg;

  // Number formats
  localparam int unsigned HUE_FRAC_BITS   = 4;
  localparam int unsigned LEVEL_FRAC_BITS = 12;
  localparam int unsigned HUE_W           = 16;
  localparam int unsigned LEVEL_W         = 13;
  localparam int unsigned CHAN_W          = 8;

  localparam int unsigned HUE_UNIT  = 1 << HUE_FRAC_BITS;
  localparam int unsigned SIXTY     = 60 * HUE_UNIT;
  localparam int unsigned PERIOD    = 360 * HUE_UNIT;
  localparam int unsigned LEVEL_ONE = 1 << LEVEL_FRAC_BITS;

  // Six full turns lift the most negative hue above zero.
  localparam int unsigned HUE_OFS = 6 * PERIOD;
  localparam int unsigned HX_W    = 17;  // offset hue, below 2^17
  localparam int unsigned WRAP_Q_W = 4;  // whole turns in the offset hue, at most 11
  localparam int unsigned HW_W    = 13;  // wrapped hue, below PERIOD
  localparam int unsigned WT_W    = 10;  // x weight, 0..SIXTY

  // floor(x / PERIOD) for x < 2^17 as (x * PWRAP_RCP) >> PWRAP_SH
  localparam int unsigned PWRAP_RCP   = 46604;
  localparam int unsigned PWRAP_RCP_W = 16;
  localparam int unsigned PWRAP_SH    = 28;

  // floor(y / SIXTY) for y < 2^18 as (y * SIX_RCP) >> SIX_SH
  localparam int unsigned SIX_RCP   = 279621;
  localparam int unsigned SIX_RCP_W = 19;
  localparam int unsigned SIX_SH    = 28;

  // Datapath widths
  localparam int unsigned VS_W   = 2 * LEVEL_FRAC_BITS + 1;  // v*s up to ONE^2
  localparam int unsigned PROD_W = 34;                       // numerators up to ONE^2*SIXTY
  localparam int unsigned NUM_W  = PROD_W + CHAN_W;          // numerator times 255
  localparam int unsigned Y_W    = 18;                       // numerator over ONE^2

  localparam logic [NUM_W-1:0] MID_RND = NUM_W'(SIXTY) << (2 * LEVEL_FRAC_BITS - 1);
  localparam int unsigned LO_RND = 1 << (2 * LEVEL_FRAC_BITS - 1);

  // Queue between front and back
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = 2;
  localparam int unsigned Q_CNT_W = 3;

  // 60-degree hue sectors, named by the two hues they run between
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_e;

  // Classified item handed from front to back
  typedef struct packed {
    sector_e              sector;
    logic [WT_W-1:0]      weight;
    logic [LEVEL_W-1:0]   sat;
    logic [LEVEL_W-1:0]   bri;
  } h2r_item_t;

endpackage

`default_nettype wire

FILE: hw/rtl/h2r_front.sv
// Front: accepts items, wraps the hue and finds sector and x weight.
`timescale 1ns / 1ps
`default_nettype none

module h2r_front import h2r_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      stall_o,
  input  logic signed [HUE_W-1:0]   hue_i,
  input  logic [LEVEL_W-1:0]        saturation_i,
  input  logic [LEVEL_W-1:0]        brightness_i,
  output logic                      push_o,
  output h2r_item_t                 item_o,
  input  logic                      full_i
);

  logic rdy1, rdy2, rdy3;
  logic v1_q, v2_q, v3_q;

  logic [HX_W:0]                     hue_ofs;
  logic [HX_W+PWRAP_RCP_W-1:0]       wrap_prod;
  logic [LEVEL_W-1:0]                sat_clip, bri_clip;

  logic [HX_W-1:0]     x1_q;
  logic [WRAP_Q_W-1:0] q1_q;
  logic [LEVEL_W-1:0]  sat1_q, bri1_q;

  logic [HW_W-1:0]     h2_d, h2_q;
  logic [LEVEL_W-1:0]  sat2_q, bri2_q;

  sector_e             sec_d;
  logic [HW_W-1:0]     start, ofs;
  logic                falling;
  logic [WT_W-1:0]     w_d;
  h2r_item_t           item3_q;

  // per-stage ready chain, ends at the queue
  assign rdy3    = !v3_q || !full_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign stall_o = !rdy1;
  assign push_o  = v3_q;
  assign item_o  = item3_q;

  // stage 1: offset hue and turn count, level clipping
  assign hue_ofs = {{(HX_W + 1 - HUE_W){hue_i[HUE_W-1]}}, hue_i} + (HX_W + 1)'(HUE_OFS);
  assign wrap_prod = (HX_W + PWRAP_RCP_W)'(hue_ofs[HX_W-1:0])
                   * (HX_W + PWRAP_RCP_W)'(PWRAP_RCP);
  assign sat_clip = (saturation_i > LEVEL_W'(LEVEL_ONE)) ? LEVEL_W'(LEVEL_ONE) : saturation_i;
  assign bri_clip = (brightness_i > LEVEL_W'(LEVEL_ONE)) ? LEVEL_W'(LEVEL_ONE) : brightness_i;

  // stage 2: wrapped hue
  assign h2_d = HW_W'(x1_q - HX_W'(q1_q) * HX_W'(PERIOD));

  // stage 3: sector and position inside it
  always_comb begin
    sec_d   = SEC_MAG_RED;
    start   = HW_W'(5 * SIXTY);
    falling = 1'b1;
    if (h2_q < HW_W'(SIXTY)) begin
      sec_d = SEC_RED_YEL; start = '0;                 falling = 1'b0;
    end else if (h2_q < HW_W'(2 * SIXTY)) begin
      sec_d = SEC_YEL_GRN; start = HW_W'(SIXTY);      falling = 1'b1;
    end else if (h2_q < HW_W'(3 * SIXTY)) begin
      sec_d = SEC_GRN_CYN; start = HW_W'(2 * SIXTY);  falling = 1'b0;
    end else if (h2_q < HW_W'(4 * SIXTY)) begin
      sec_d = SEC_CYN_BLU; start = HW_W'(3 * SIXTY);  falling = 1'b1;
    end else if (h2_q < HW_W'(5 * SIXTY)) begin
      sec_d = SEC_BLU_MAG; start = HW_W'(4 * SIXTY);  falling = 1'b0;
    end
    ofs = h2_q - start;
    w_d = falling ? (WT_W'(SIXTY) - WT_W'(ofs)) : WT_W'(ofs);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      x1_q   <= hue_ofs[HX_W-1:0];
      q1_q   <= wrap_prod[PWRAP_SH +: WRAP_Q_W];
      sat1_q <= sat_clip;
      bri1_q <= bri_clip;
    end
    if (rdy2 && v1_q) begin
      h2_q   <= h2_d;
      sat2_q <= sat1_q;
      bri2_q <= bri1_q;
    end
    if (rdy3 && v2_q) begin
      item3_q.sector <= sec_d;
      item3_q.weight <= w_d;
      item3_q.sat    <= sat2_q;
      item3_q.bri    <= bri2_q;
    end
  end

`ifndef SYNTH
  a_hue_wrapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> (h2_q < HW_W'(PERIOD)))
    else $error("wrapped hue out of range");

  a_weight_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (item3_q.weight <= WT_W'(SIXTY)))
    else $error("x weight above sixty degrees");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/h2r_queue.sv
// Short item queue between front and back.
`timescale 1ns / 1ps
`default_nettype none

module h2r_queue import h2r_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  h2r_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output h2r_item_t item_o,
  output logic      empty_o
);

  h2r_item_t            entry_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_q, rd_q;
  logic [Q_CNT_W-1:0]   cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = entry_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_q] <= item_i;
  end

`ifndef SYNTH
  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !full_o && !pop_i) |=> !empty_o)
    else $error("queue empty after a push");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/h2r_back.sv
// Back: chroma products, rounding to bytes and channel assignment.
`timescale 1ns / 1ps
`default_nettype none

module h2r_back import h2r_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  h2r_item_t         item_i,
  output logic              pop_o,
  output logic              valid_o,
  input  logic              stall_i,
  output logic [CHAN_W-1:0] red_o,
  output logic [CHAN_W-1:0] green_o,
  output logic [CHAN_W-1:0] blue_o
);

  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  // stage 1
  logic [2*LEVEL_W-1:0]        vs_prod;
  logic [LEVEL_W+CHAN_W-1:0]   bri255;
  sector_e                     sec1_q;
  logic [WT_W-1:0]             w1_q;
  logic [LEVEL_W-1:0]          bri1_q;
  logic [VS_W-1:0]             vs1_q;
  logic [CHAN_W-1:0]           hib1_q;

  // stage 2
  logic [VS_W-1:0]             lo;
  logic [VS_W+CHAN_W-1:0]      lo255;
  sector_e                     sec2_q;
  logic [CHAN_W-1:0]           hib2_q, lob2_q;
  logic [PROD_W-1:0]           p1_q, p2_q;

  // stage 3
  sector_e                     sec3_q;
  logic [CHAN_W-1:0]           hib3_q, lob3_q;
  logic [PROD_W-1:0]           mid3_q;

  // stage 4
  logic [NUM_W-1:0]            num;
  sector_e                     sec4_q;
  logic [CHAN_W-1:0]           hib4_q, lob4_q;
  logic [Y_W-1:0]              y4_q;

  // stage 5
  logic [Y_W+SIX_RCP_W-1:0]    six_prod;
  logic [CHAN_W-1:0]           midb;
  logic [CHAN_W-1:0]           red_d, green_d, blue_d;
  logic [CHAN_W-1:0]           red_q, green_q, blue_q;

  assign rdy5  = !v5_q || !stall_i;
  assign rdy4  = !v4_q || rdy5;
  assign rdy3  = !v3_q || rdy4;
  assign rdy2  = !v2_q || rdy3;
  assign rdy1  = !v1_q || rdy2;
  assign pop_o = !empty_i && rdy1;

  assign valid_o = v5_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

  // v*s, and the byte of the largest channel: round(v*255/ONE)
  assign vs_prod = (2 * LEVEL_W)'(item_i.bri) * (2 * LEVEL_W)'(item_i.sat);
  assign bri255  = {item_i.bri, CHAN_W'(0)} - (LEVEL_W + CHAN_W)'(item_i.bri)
                 + (LEVEL_W + CHAN_W)'(LEVEL_ONE / 2);

  // base over ONE^2 and its byte; products for the middle channel
  assign lo    = {bri1_q, LEVEL_FRAC_BITS'(0)} - vs1_q;
  assign lo255 = {lo, CHAN_W'(0)} - (VS_W + CHAN_W)'(lo) + (VS_W + CHAN_W)'(LO_RND);

  // middle channel times 255 plus half the denominator, over ONE^2
  assign num = {mid3_q, CHAN_W'(0)} - NUM_W'(mid3_q) + MID_RND;

  // remaining division by SIXTY
  assign six_prod = (Y_W + SIX_RCP_W)'(y4_q) * (Y_W + SIX_RCP_W)'(SIX_RCP);
  assign midb     = six_prod[SIX_SH +: CHAN_W];

  always_comb begin
    case (sec4_q)
      SEC_RED_YEL: begin red_d = hib4_q; green_d = midb;   blue_d = lob4_q; end
      SEC_YEL_GRN: begin red_d = midb;   green_d = hib4_q; blue_d = lob4_q; end
      SEC_GRN_CYN: begin red_d = lob4_q; green_d = hib4_q; blue_d = midb;   end
      SEC_CYN_BLU: begin red_d = lob4_q; green_d = midb;   blue_d = hib4_q; end
      SEC_BLU_MAG: begin red_d = midb;   green_d = lob4_q; blue_d = hib4_q; end
      SEC_MAG_RED: begin red_d = hib4_q; green_d = lob4_q; blue_d = midb;   end
      default:     begin red_d = lob4_q; green_d = lob4_q; blue_d = lob4_q; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= !empty_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      sec1_q <= item_i.sector;
      w1_q   <= item_i.weight;
      bri1_q <= item_i.bri;
      vs1_q  <= vs_prod[VS_W-1:0];
      hib1_q <= bri255[LEVEL_FRAC_BITS +: CHAN_W];
    end
    if (rdy2 && v1_q) begin
      sec2_q <= sec1_q;
      hib2_q <= hib1_q;
      lob2_q <= lo255[2 * LEVEL_FRAC_BITS +: CHAN_W];
      p1_q   <= PROD_W'(vs1_q) * PROD_W'(w1_q);
      p2_q   <= PROD_W'(lo) * PROD_W'(SIXTY);
    end
    if (rdy3 && v2_q) begin
      sec3_q <= sec2_q;
      hib3_q <= hib2_q;
      lob3_q <= lob2_q;
      mid3_q <= p1_q + p2_q;
    end
    if (rdy4 && v3_q) begin
      sec4_q <= sec3_q;
      hib4_q <= hib3_q;
      lob4_q <= lob3_q;
      y4_q   <= num[2 * LEVEL_FRAC_BITS +: Y_W];
    end
    if (rdy5 && v4_q) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

`ifndef SYNTH
  a_hi_above_lo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> (hib2_q >= lob2_q))
    else $error("largest channel below base channel");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v5_q && stall_i) |=> (v5_q && $stable(red_q) && $stable(green_q) && $stable(blue_q)))
    else $error("result changed while stalled");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/hsv_to_rgb_converter_top.sv
// Top level of the HSV to RGB converter.
`timescale 1ns / 1ps
`default_nettype none

// Converts one HSV item per clock, stalls aside, into an 8-bit RGB item.
// Hue is signed degrees with 4 fraction bits and is wrapped into 0..360;
// saturation and brightness are Q1.12 and are clipped to 1.0. Each channel
// is the exact (chan + base) * 255 rounded half up; the final rounding is
// the only one in the datapath. Throughput is one item per clock with no
// gaps while nothing stalls: every step is fully pipelined. An item passes
// 3 front stages (hue offset and turn count, wrap, sector classify), the
// 4-entry queue, and 5 back stages (v*s, chroma products, sum, scale by
// 255, divide by sixty and assign channels). The output register holds a
// result while stall_i is high; the queue lets the front keep taking items
// while the back is stalled until it fills, and stall_o comes from
// registers only, never combinationally from stall_i.

module hsv_to_rgb_converter_top import h2r_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    stall_o,
  input  logic signed [HUE_W-1:0] hue_i,
  input  logic [LEVEL_W-1:0]      saturation_i,
  input  logic [LEVEL_W-1:0]      brightness_i,
  output logic                    valid_o,
  input  logic                    stall_i,
  output logic [CHAN_W-1:0]       red_o,
  output logic [CHAN_W-1:0]       green_o,
  output logic [CHAN_W-1:0]       blue_o
);

  logic      push, full, pop, empty;
  h2r_item_t front_item, back_item;

  // front: wraps the hue and classifies the sector
  h2r_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .stall_o      (stall_o),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .push_o       (push),
    .item_o       (front_item),
    .full_i       (full)
  );

  // decouples the two halves
  h2r_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (back_item),
    .empty_o (empty)
  );

  // back: arithmetic, rounding and channel placement
  h2r_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .item_i  (back_item),
    .pop_o   (pop),
    .valid_o (valid_o),
    .stall_i (stall_i),
    .red_o   (red_o),
    .green_o (green_o),
    .blue_o  (blue_o)
  );

endmodule

`default_nettype wire

FILE: verif/hsv_to_rgb_checker.sv
// Checker for the HSV to RGB converter: predicts each pixel and compares the results.
`timescale 1ns / 1ps

module hsv_to_rgb_checker import h2r_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic signed [HUE_W-1:0] hue_i,
  input  logic [LEVEL_W-1:0]      saturation_i,
  input  logic [LEVEL_W-1:0]      brightness_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic [CHAN_W-1:0]       red_i,
  input  logic [CHAN_W-1:0]       green_i,
  input  logic [CHAN_W-1:0]       blue_i,
  output int                      fail_cnt_o,
  output int                      pending_o,
  output int                      checked_o,
  output logic [5:0]              sectors_o
);

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  typedef struct {
    logic signed [HUE_W-1:0] hue;
    logic [LEVEL_W-1:0]      sat;
    logic [LEVEL_W-1:0]      bri;
    rgb_t                    rgb;
  } pixel_t;

  pixel_t     rgb_expect_q[$];
  int         fails;
  int         checked;
  logic [5:0] sectors;

  // (num * 255) / den, rounded half up, clipped to a byte
  function automatic logic [CHAN_W-1:0] to_chan(longint unsigned num, longint unsigned den);
    longint unsigned q;
    q = (num * 64'd255 + den / 64'd2) / den;
    return (q > 64'd255) ? 8'd255 : q[CHAN_W-1:0];
  endfunction

  // Exact rational conversion over the common denominator ONE*ONE*SIXTY
  function automatic rgb_t hsv_to_rgb(input logic signed [HUE_W-1:0] hue,
                                      input logic [LEVEL_W-1:0] sat,
                                      input logic [LEVEL_W-1:0] bri,
                                      output sector_e sec);
    longint          per, six, hs, h, t, hdev;
    longint unsigned one, s, v, w, den, cn, xn, bn, rn, gn, bln;
    rgb_t            px;
    per  = PERIOD;
    six  = SIXTY;
    one  = LEVEL_ONE;
    hs   = hue;
    h    = ((hs % per) + per) % per;
    s    = (sat > one) ? one : sat;
    v    = (bri > one) ? one : bri;
    t    = h % (2 * six);
    hdev = t - six;
    if (hdev < 0) begin
      hdev = -hdev;
    end
    w    = six - hdev;
    den  = one * one * six;
    cn   = v * s * six;
    xn   = v * s * w;
    bn   = v * one * six - cn;
    rn   = 0;
    gn   = 0;
    bln  = 0;
    sec  = sector_e'(3'(h / six));
    case (sec)
      SEC_RED_YEL: begin rn = cn; gn = xn; end
      SEC_YEL_GRN: begin rn = xn; gn = cn; end
      SEC_GRN_CYN: begin gn = cn; bln = xn; end
      SEC_CYN_BLU: begin gn = xn; bln = cn; end
      SEC_BLU_MAG: begin rn = xn; bln = cn; end
      default:     begin rn = cn; bln = xn; end
    endcase
    px.red   = to_chan(rn + bn, den);
    px.green = to_chan(gn + bn, den);
    px.blue  = to_chan(bln + bn, den);
    return px;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pixel_t  px;
    pixel_t  want;
    sector_e sec;
    if (!rst_ni) begin
      rgb_expect_q.delete();
      fails   = 0;
      checked = 0;
      sectors = '0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        px.hue = hue_i;
        px.sat = saturation_i;
        px.bri = brightness_i;
        px.rgb = hsv_to_rgb(hue_i, saturation_i, brightness_i, sec);
        sectors[sec] = 1'b1;
        rgb_expect_q.push_back(px);
      end
      if (out_valid_i && !out_stall_i) begin
        if (rgb_expect_q.size() == 0) begin
          $error("unexpected result r=%0d g=%0d b=%0d", red_i, green_i, blue_i);
          fails++;
        end else begin
          want = rgb_expect_q.pop_front();
          checked++;
          if (red_i !== want.rgb.red) begin
            $error("red: expected %0d, actual %0d (hue %0d sat %0d bri %0d)",
                   want.rgb.red, red_i, want.hue, want.sat, want.bri);
            fails++;
          end
          if (green_i !== want.rgb.green) begin
            $error("green: expected %0d, actual %0d (hue %0d sat %0d bri %0d)",
                   want.rgb.green, green_i, want.hue, want.sat, want.bri);
            fails++;
          end
          if (blue_i !== want.rgb.blue) begin
            $error("blue: expected %0d, actual %0d (hue %0d sat %0d bri %0d)",
                   want.rgb.blue, blue_i, want.hue, want.sat, want.bri);
            fails++;
          end
        end
      end
    end
    fail_cnt_o <= fails;
    pending_o  <= rgb_expect_q.size();
    checked_o  <= checked;
    sectors_o  <= sectors;
  end

endmodule

FILE: verif/tb_hsv_to_rgb_converter_top.sv
// Testbench top for the HSV to RGB converter: stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module tb_hsv_to_rgb_converter_top;
  import h2r_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 9;
  localparam int RAND_ITEMS   = 450;
  localparam int SEG_LEN      = 25;   // random items per idling regime
  localparam int HOLD_CYCLES  = 64;   // long output hold, well past pipe + queue depth
  localparam int DRAIN_CYCLES = 30;   // leave slack for stray results
  localparam int CYCLE_LIMIT  = 200000;
  localparam int TURN         = 360 * 16;  // one full hue turn in input units
  localparam int EDGE         = 60 * 16;   // one sector in input units

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    valid_i;
  logic                    stall_o;
  logic signed [HUE_W-1:0] hue_i;
  logic [LEVEL_W-1:0]      saturation_i;
  logic [LEVEL_W-1:0]      brightness_i;
  logic                    valid_o;
  logic                    stall_i;
  logic [CHAN_W-1:0]       red_o;
  logic [CHAN_W-1:0]       green_o;
  logic [CHAN_W-1:0]       blue_o;

  int         fail_cnt;
  int         pending;
  int         checked;
  logic [5:0] sectors;

  // Idling regime, shared by the sender and the receiver
  bit calm;       // no sender gaps and no new receiver stalls for this stretch
  bit in_burst;   // sender goes back to back while the receiver holds
  int burst_id;   // bumped once per burst; receiver answers with one long hold

  int sent;
  int holds;
  int cycles;
  int backpressure_cycles;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  hsv_to_rgb_converter_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .stall_o      (stall_o),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .valid_o      (valid_o),
    .stall_i      (stall_i),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o)
  );

  // Watches both channels, predicts each pixel and counts mismatches.
  hsv_to_rgb_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (valid_i),
    .in_stall_i   (stall_o),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .out_valid_i  (valid_o),
    .out_stall_i  (stall_i),
    .red_i        (red_o),
    .green_i      (green_o),
    .blue_i       (blue_o),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending),
    .checked_o    (checked),
    .sectors_o    (sectors)
  );

  // Watchdog, plus a count of cycles where the block pushed back on the sender.
  always @(posedge clk_i) begin
    cycles++;
    if (valid_i && stall_o) begin
      backpressure_cycles++;
    end
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycles, pending);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Sender gap: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (calm || in_burst) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Level in Q1.12: mostly in 0..1, with the ends and the clipped range
  // above one (all 13 bits) mixed in.
  function automatic int rand_level();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return LEVEL_ONE;
    if (r == 2) return $urandom_range(0, (1 << LEVEL_W) - 1);
    return $urandom_range(0, LEVEL_ONE);
  endfunction

  // Offer one pixel and hold it until the block takes it. Called at a
  // falling edge, returns at the falling edge after acceptance. valid_i
  // stays high across back-to-back items, so it gets one assignment per step.
  task automatic send_pixel(input int hue, input int sat, input int bri);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    valid_i      <= 1'b1;
    hue_i        <= hue[HUE_W-1:0];
    saturation_i <= sat[LEVEL_W-1:0];
    brightness_i <= bri[LEVEL_W-1:0];
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
  endtask

  // Receiver: random stalls at the falling edge, one long hold per burst.
  initial begin : receiver
    int r;
    int stall_left;
    int hold_seen;
    stall_i    = 1'b0;
    stall_left = 0;
    hold_seen  = 0;
    forever begin
      @(negedge clk_i);
      if (hold_seen != burst_id) begin
        // Hold off long enough for the pipe and the queue to fill, so the
        // block must stall the sender.
        hold_seen = burst_id;
        holds++;
        stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else if (stall_left > 0) begin
        stall_i <= 1'b1;
        stall_left--;
      end else if (calm) begin
        stall_i <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          stall_i <= 1'b0;
        end else if (r < 95) begin
          stall_i    <= 1'b1;
          stall_left = $urandom_range(0, 2);
        end else begin
          stall_i    <= 1'b1;
          stall_left = $urandom_range(8, 30);
        end
      end
    end
  end

  initial begin : stimulus
    int r;
    int hue;
    rst_ni       = 1'b0;
    valid_i      = 1'b0;
    hue_i        = '0;
    saturation_i = '0;
    brightness_i = '0;
    calm         = 1'b0;
    in_burst     = 1'b0;
    burst_id     = 0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: pure hues and every sector edge at full level
    send_pixel(0, LEVEL_ONE, LEVEL_ONE);
    send_pixel(EDGE, LEVEL_ONE, LEVEL_ONE);
    send_pixel(2 * EDGE, LEVEL_ONE, LEVEL_ONE);
    send_pixel(3 * EDGE, LEVEL_ONE, LEVEL_ONE);
    send_pixel(4 * EDGE, LEVEL_ONE, LEVEL_ONE);
    send_pixel(5 * EDGE, LEVEL_ONE, LEVEL_ONE);
    send_pixel(TURN - 1, LEVEL_ONE, LEVEL_ONE);   // just under a full turn
    send_pixel(TURN, LEVEL_ONE, LEVEL_ONE);       // full turn wraps to red
    // Negative hues wrap up, including the most negative code
    send_pixel(-1, LEVEL_ONE, LEVEL_ONE);
    send_pixel(-EDGE, LEVEL_ONE, 2048);
    send_pixel(-32768, LEVEL_ONE, LEVEL_ONE);
    send_pixel(32767, LEVEL_ONE, LEVEL_ONE);
    send_pixel(-21846, 1, 8190);
    send_pixel(21845, 6000, 1234);
    send_pixel(1, LEVEL_ONE, LEVEL_ONE);
    // Zero and clipped levels
    send_pixel(EDGE / 2, 0, LEVEL_ONE);
    send_pixel(EDGE / 2, LEVEL_ONE, 0);
    send_pixel(EDGE / 2, (1 << LEVEL_W) - 1, (1 << LEVEL_W) - 1);
    send_pixel(EDGE / 2, LEVEL_ONE + 1, LEVEL_ONE - 1);
    // Exact halves round up: grey at half level, and x at half chroma
    send_pixel(0, 0, LEVEL_ONE / 2);
    send_pixel(EDGE / 2, LEVEL_ONE, LEVEL_ONE);
    send_pixel(5 * EDGE / 2, LEVEL_ONE / 2, 3000);

    // Random part, in stretches with their own idling regime. Two stretches
    // are bursts against a long output hold.
    for (int seg = 0; seg < RAND_ITEMS / SEG_LEN; seg++) begin
      in_burst = (seg == 4) || (seg == 13);
      calm     = !in_burst && ($urandom_range(0, 3) == 0);
      if (in_burst) begin
        burst_id++;
      end
      for (int i = 0; i < SEG_LEN; i++) begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          // near a sector edge, a few turns either way
          hue = $urandom_range(0, 5) * EDGE + $urandom_range(0, 2) - 1
                + ($urandom_range(0, 9) - 5) * TURN;
        end else begin
          hue = $urandom_range(0, (1 << HUE_W) - 1);
        end
        send_pixel(hue, rand_level(), rand_level());
      end
    end
    in_burst = 1'b0;
    valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d pixels, %0d results checked, hue sectors reached 6'b%b.",
             sent, checked, sectors);
    $display("%0d long output holds; sender pushed back on %0d cycles.",
             holds, backpressure_cycles);
    if (fail_cnt == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/h2r_pkg.sv
hw/rtl/h2r_front.sv
hw/rtl/h2r_queue.sv
hw/rtl/h2r_back.sv
hw/rtl/hsv_to_rgb_converter_top.sv
verif/hsv_to_rgb_checker.sv
verif/tb_hsv_to_rgb_converter_top.sv
